### design/sqvg_pkg.sv
// ----------------------------------------------------------------------------
// sqvg_pkg
// Shared types, constants and helpers of the sprite quad vertex generator.
// ----------------------------------------------------------------------------
package sqvg_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int VERTS_DEF     = 6;

	// quotient width of the repeat factor, saturating at 2^31-1
	localparam int Q_W           = 31;
	localparam int DIV_STEPS     = Q_W;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	// corner bit per vertex, vertex 0 in bit 0
	localparam logic [VERTS_DEF-1:0] CORNER_X = 6'b110100;
	localparam logic [VERTS_DEF-1:0] CORNER_Y = 6'b101001;

	// one lane of the restoring divider
	typedef struct packed {
		logic [32:0]    rem;
		logic [Q_W-1:0] nlow;
		logic [Q_W-1:0] q;
		logic [32:0]    d;
		logic           ovf;
	} lane_t;

	// per-quad data riding alongside the divider
	typedef struct packed {
		logic [15:0]    pos_x0;
		logic [15:0]    pos_x1;
		logic [15:0]    pos_y0;
		logic [15:0]    pos_y1;
		logic [31:0]    origin_x;
		logic [31:0]    origin_y;
		logic [Q_W-1:0] size_x;
		logic [Q_W-1:0] size_y;
		logic           bad;
	} side_t;

	function automatic logic [15:0] sat16(input logic signed [34:0] v);
		logic [15:0] r;
		if (v > 35'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -35'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic [Q_W-1:0] sat31(input logic signed [33:0] v);
		logic [Q_W-1:0] r;
		if (v < 34'sd0) begin
			r = '0;
		end else if (v > 34'sd2147483647) begin
			r = '1;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	// one restoring step: bring down the next dividend bit, subtract if it fits
	function automatic lane_t div_step(input lane_t a);
		lane_t       b;
		logic [33:0] r2;
		logic        ge;
		r2     = {a.rem, a.nlow[Q_W-1]};
		ge     = (r2 >= {1'b0, a.d});
		b      = a;
		b.nlow = {a.nlow[Q_W-2:0], 1'b0};
		b.q    = {a.q[Q_W-2:0], ge};
		b.rem  = ge ? 33'(r2 - {1'b0, a.d}) : r2[32:0];
		return b;
	endfunction

endpackage

### design/sqvg_if.sv
// ----------------------------------------------------------------------------
// sqvg_if
// Valid/ready channels: quad requests in, vertices out.
// ----------------------------------------------------------------------------
interface sqvg_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] offset_x;
	logic signed [31:0] offset_y;
	logic signed [31:0] quad_width;
	logic signed [31:0] quad_height;
	logic signed [31:0] tex_left;
	logic signed [31:0] tex_top;
	logic signed [31:0] tex_right;
	logic signed [31:0] tex_bottom;

	modport source (
		output valid, func, offset_x, offset_y, quad_width, quad_height,
		       tex_left, tex_top, tex_right, tex_bottom,
		input  ready
	);
	modport sink (
		input  valid, func, offset_x, offset_y, quad_width, quad_height,
		       tex_left, tex_top, tex_right, tex_bottom,
		output ready
	);
endinterface

interface sqvg_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic        [30:0] tex_u;
	logic        [30:0] tex_v;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic        [30:0] size_x;
	logic        [30:0] size_y;
	logic               bad;
	logic               last;

	modport source (
		output valid, pos_x, pos_y, tex_u, tex_v, origin_x, origin_y,
		       size_x, size_y, bad, last,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, tex_u, tex_v, origin_x, origin_y,
		       size_x, size_y, bad, last,
		output ready
	);
endinterface

### design/sqvg_div_pipe.sv
// ----------------------------------------------------------------------------
// sqvg_div_pipe
// Pipelined restoring divider, two lanes (u and v), side data carried along.
// ----------------------------------------------------------------------------
module sqvg_div_pipe
	import sqvg_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_valid,
	input  lane_t          in_u,
	input  lane_t          in_v,
	input  side_t          in_side,
	output logic           out_valid,
	output logic [Q_W-1:0] out_u,
	output logic [Q_W-1:0] out_v,
	output side_t          out_side
);

	logic [DIV_STAGES-1:0] vld_s;
	lane_t                 u_s    [DIV_STAGES];
	lane_t                 v_s    [DIV_STAGES];
	side_t                 side_s [DIV_STAGES];

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		logic  src_vld;
		lane_t src_u;
		lane_t src_v;
		side_t src_side;
		lane_t nxt_u;
		lane_t nxt_v;

		if (s == 0) begin : g_first
			assign src_vld  = in_valid;
			assign src_u    = in_u;
			assign src_v    = in_v;
			assign src_side = in_side;
		end else begin : g_next
			assign src_vld  = vld_s[s-1];
			assign src_u    = u_s[s-1];
			assign src_v    = v_s[s-1];
			assign src_side = side_s[s-1];
		end

		always_comb begin
			nxt_u = src_u;
			nxt_v = src_v;
			for (int j = 0; j < DIV_PER_STAGE; j++) begin
				if (s * DIV_PER_STAGE + j < DIV_STEPS) begin
					nxt_u = div_step(nxt_u);
					nxt_v = div_step(nxt_v);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (adv) begin
				vld_s[s] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				u_s[s]    <= nxt_u;
				v_s[s]    <= nxt_v;
				side_s[s] <= src_side;
			end
		end
	end

	// overflow means the quotient reached 2^31: saturate
	assign out_valid = vld_s[DIV_STAGES-1];
	assign out_u     = u_s[DIV_STAGES-1].ovf ? '1 : u_s[DIV_STAGES-1].q;
	assign out_v     = v_s[DIV_STAGES-1].ovf ? '1 : v_s[DIV_STAGES-1].q;
	assign out_side  = side_s[DIV_STAGES-1];

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("divider valids moved during stall");

	a_u_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STAGES-1] && !u_s[DIV_STAGES-1].ovf
		|-> u_s[DIV_STAGES-1].rem < u_s[DIV_STAGES-1].d)
		else $error("u remainder not below divisor");

	a_v_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STAGES-1] && !v_s[DIV_STAGES-1].ovf
		|-> v_s[DIV_STAGES-1].rem < v_s[DIV_STAGES-1].d)
		else $error("v remainder not below divisor");

endmodule

### design/sprite_quad_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator_top
// Turns one sprite quad request into six vertices (two triangles).
// ----------------------------------------------------------------------------
// Usage:
//   req : quad requests (valid/ready). One transfer per quad.
//   vtx : vertices (valid/ready). Six transfers per good quad, the sixth with
//         last set; a rejected quad gives a single transfer with bad and last
//         set and every other field zero.
// Pipeline: a request passes two setup stages, 16 divider stages and the
//   vertex register before its first vertex is offered.
// Throughput: the vertex port moves one vertex per cycle while vtx.ready is
//   high; the repeat-factor divider, two quotient bits per stage, takes a new
//   quad every cycle while the pipeline advances and does not limit it.
// Stall: when vtx.ready is low the vertex register holds its vertex; the
//   pipeline keeps taking requests until a quad reaches the divider tail,
//   then freezes as a whole, so nothing is lost or repeated.
// Reset: arst_n clears all valid bits; the block takes requests right away.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator_top
	import sqvg_pkg::*;
#(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int VERTS_PER_QUAD = VERTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sqvg_req_if.sink   req,
	sqvg_vtx_if.source vtx
);

	localparam int IDX_W = $clog2(VERTS_PER_QUAD);
	// dividend width: 33-bit size shifted up by the fraction
	localparam int NW    = 33 + FRAC_BITS;
	localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VERTS_PER_QUAD - 1);

	// global advance: pipeline moves unless its tail waits on the vertex register
	logic adv;
	logic exp_take;
	logic div_vld;
	logic [Q_W-1:0] div_u;
	logic [Q_W-1:0] div_v;
	side_t div_side;

	// ---- stage 1: sizes, effective width/height, reject test ----
	logic signed [33:0] sx_c, sy_c, w_c, h_c;
	logic               bad_c;

	logic               valid_s1;
	logic signed [33:0] sx_s1, sy_s1, w_s1, h_s1;
	logic signed [31:0] ox_s1, oy_s1, left_s1, top_s1;
	logic               bad_s1;

	always_comb begin
		sx_c  = 34'(req.tex_right) - 34'(req.tex_left) + ONE;
		sy_c  = 34'(req.tex_bottom) - 34'(req.tex_top) + ONE;
		w_c   = req.func ? sx_c : 34'(req.quad_width);
		h_c   = req.func ? sy_c : 34'(req.quad_height);
		bad_c = (w_c < 34'sd0) || (h_c < 34'sd0) ||
		        (req.tex_left > req.tex_right) || (req.tex_top > req.tex_bottom);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1   <= sx_c;
			sy_s1   <= sy_c;
			w_s1    <= w_c;
			h_s1    <= h_c;
			ox_s1   <= req.offset_x;
			oy_s1   <= req.offset_y;
			left_s1 <= req.tex_left;
			top_s1  <= req.tex_top;
			bad_s1  <= bad_c;
		end
	end

	// ---- stage 2: floored positions, divider setup ----
	logic signed [34:0] x1_sum, y1_sum;
	logic [NW-1:0]      nu, nv;
	logic [NW-32:0]     ru0, rv0;
	side_t              side_c;
	lane_t              u_c, v_c;

	logic               valid_s2;
	side_t              side_s2;
	lane_t              u_s2, v_s2;

	always_comb begin
		x1_sum = 35'(ox_s1) + 35'(w_s1);
		y1_sum = 35'(oy_s1) + 35'(h_s1);

		// floor is an arithmetic shift in two's complement
		side_c.pos_x0   = sat16(35'(ox_s1) >>> FRAC_BITS);
		side_c.pos_x1   = sat16(x1_sum >>> FRAC_BITS);
		side_c.pos_y0   = sat16(35'(oy_s1) >>> FRAC_BITS);
		side_c.pos_y1   = sat16(y1_sum >>> FRAC_BITS);
		side_c.origin_x = left_s1;
		side_c.origin_y = top_s1;
		side_c.size_x   = sat31(sx_s1);
		side_c.size_y   = sat31(sy_s1);
		side_c.bad      = bad_s1;

		// dividend = size << FRAC; top part must stay below the divisor,
		// else the quotient is 2^31 or more
		nu  = NW'(w_s1[32:0]) << FRAC_BITS;
		nv  = NW'(h_s1[32:0]) << FRAC_BITS;
		ru0 = nu[NW-1:Q_W];
		rv0 = nv[NW-1:Q_W];

		u_c.rem  = 33'(ru0);
		u_c.nlow = nu[Q_W-1:0];
		u_c.q    = '0;
		u_c.d    = sx_s1[32:0];
		u_c.ovf  = (34'(ru0) >= 34'(sx_s1[32:0]));

		v_c.rem  = 33'(rv0);
		v_c.nlow = nv[Q_W-1:0];
		v_c.q    = '0;
		v_c.d    = sy_s1[32:0];
		v_c.ovf  = (34'(rv0) >= 34'(sy_s1[32:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_c;
			u_s2    <= u_c;
			v_s2    <= v_c;
		end
	end

	// ---- stages 3..18: repeat factors ----
	sqvg_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (valid_s2),
		.in_u      (u_s2),
		.in_v      (v_s2),
		.in_side   (side_s2),
		.out_valid (div_vld),
		.out_u     (div_u),
		.out_v     (div_v),
		.out_side  (div_side)
	);

	// ---- vertex register: walks the six corners of one quad (one transfer if rejected) ----
	logic             exp_valid_q;
	logic [IDX_W-1:0] exp_idx_q;
	side_t            exp_side_q;
	logic [Q_W-1:0]   exp_u_q;
	logic [Q_W-1:0]   exp_v_q;
	logic             exp_last;
	logic             cx, cy;

	assign exp_last  = exp_side_q.bad || (exp_idx_q == LAST_IDX);
	assign exp_take  = !exp_valid_q || (vtx.ready && exp_last);
	assign adv       = !div_vld || exp_take;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_valid_q <= 1'b0;
			exp_idx_q   <= '0;
		end else if (exp_take) begin
			exp_valid_q <= div_vld;
			exp_idx_q   <= '0;
		end else if (vtx.ready) begin
			exp_idx_q   <= exp_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (exp_take) begin
			exp_side_q <= div_side;
			exp_u_q    <= div_u;
			exp_v_q    <= div_v;
		end
	end

	always_comb begin
		cx = CORNER_X[exp_idx_q];
		cy = CORNER_Y[exp_idx_q];

		vtx.valid = exp_valid_q;
		vtx.bad   = exp_side_q.bad;
		vtx.last  = exp_last;
		if (exp_side_q.bad) begin
			vtx.pos_x    = '0;
			vtx.pos_y    = '0;
			vtx.tex_u    = '0;
			vtx.tex_v    = '0;
			vtx.origin_x = '0;
			vtx.origin_y = '0;
			vtx.size_x   = '0;
			vtx.size_y   = '0;
		end else begin
			vtx.pos_x    = cx ? exp_side_q.pos_x1 : exp_side_q.pos_x0;
			vtx.pos_y    = cy ? exp_side_q.pos_y1 : exp_side_q.pos_y0;
			vtx.tex_u    = cx ? exp_u_q : '0;
			vtx.tex_v    = cy ? exp_v_q : '0;
			vtx.origin_x = exp_side_q.origin_x;
			vtx.origin_y = exp_side_q.origin_y;
			vtx.size_x   = exp_side_q.size_x;
			vtx.size_y   = exp_side_q.size_y;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid_q |-> exp_idx_q <= LAST_IDX)
		else $error("vertex index past end of quad");

	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid_q && exp_side_q.bad |-> exp_idx_q == '0)
		else $error("rejected quad gave more than one transfer");

	a_hold_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid_q && !vtx.ready |=> exp_valid_q && $stable(exp_idx_q))
		else $error("vertex changed while stalled");

endmodule

### bench/sqvg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqvg_checker
// Watches the request and vertex channels. For every quad request transfer it
// computes the vertices the generator must emit and queues them. Every vertex
// transfer is then compared, field by field, against the oldest of them.
// ----------------------------------------------------------------------------
module sqvg_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	sqvg_req_if  req,
	sqvg_vtx_if  vtx,
	output int   errors,
	output int   pending
);

	localparam longint ONE   = longint'(1) << FRAC_BITS;
	localparam longint MAX31 = 64'h7FFF_FFFF;
	// triangle corners in emission order, vertex 0 leftmost
	localparam bit [0:5] X_SIDE = 6'b001011;
	localparam bit [0:5] Y_SIDE = 6'b100101;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic        [30:0] tex_u;
		logic        [30:0] tex_v;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic        [30:0] size_x;
		logic        [30:0] size_y;
		logic               bad;
		logic               last;
	} vertex_t;

	vertex_t expected_vertices[$];
	int      mism     = 0;
	int      queued   = 0;
	int      vtx_seen = 0;

	assign errors  = mism;
	assign pending = queued;

	// floor to whole pixels, then clamp to 16 bits
	function automatic logic [15:0] clamp_pos(input longint v);
		longint f;
		f = v >>> FRAC_BITS;
		if (f > 32767) begin
			f = 32767;
		end else if (f < -32768) begin
			f = -32768;
		end
		return 16'(f);
	endfunction

	function automatic logic [30:0] clamp31(input longint v);
		if (v < 0) begin
			return '0;
		end else if (v > MAX31) begin
			return '1;
		end
		return 31'(v);
	endfunction

	function automatic void predict_vertices(input logic fn, input longint ox, input longint oy,
			input longint qw, input longint qh, input longint lf, input longint tp,
			input longint rt, input longint bt);
		vertex_t v;
		longint  sx, sy, w, h, ru, rv;
		int      i;
		v  = '0;
		// inclusive rectangle: size is one texel more than the edge difference
		sx = rt - lf + ONE;
		sy = bt - tp + ONE;
		w  = fn ? sx : qw;
		h  = fn ? sy : qh;
		if (w < 0 || h < 0 || lf > rt || tp > bt) begin
			v.bad  = 1'b1;
			v.last = 1'b1;
			expected_vertices.push_back(v);
		end else begin
			ru = (w << FRAC_BITS) / sx;
			rv = (h << FRAC_BITS) / sy;
			v.origin_x = 32'(lf);
			v.origin_y = 32'(tp);
			v.size_x   = clamp31(sx);
			v.size_y   = clamp31(sy);
			for (i = 0; i < 6; i++) begin
				v.pos_x = clamp_pos(ox + (X_SIDE[i] ? w : 0));
				v.pos_y = clamp_pos(oy + (Y_SIDE[i] ? h : 0));
				v.tex_u = X_SIDE[i] ? clamp31(ru) : '0;
				v.tex_v = Y_SIDE[i] ? clamp31(rv) : '0;
				v.last  = (i == 5);
				expected_vertices.push_back(v);
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		mism++;
		$display("chk: vertex %0d: %s", vtx_seen, msg);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
		end
	endtask

	always @(posedge clk) begin
		vertex_t want;
		if (arst_n) begin
			// check before predicting: a request never answers in its own cycle
			if (vtx.valid && vtx.ready) begin
				if (expected_vertices.size() == 0) begin
					report_mismatch("transfer with no vertex pending");
				end else begin
					want = expected_vertices.pop_front();
					compare_field("pos_x", vtx.pos_x, want.pos_x);
					compare_field("pos_y", vtx.pos_y, want.pos_y);
					compare_field("tex_u", vtx.tex_u, want.tex_u);
					compare_field("tex_v", vtx.tex_v, want.tex_v);
					compare_field("origin_x", vtx.origin_x, want.origin_x);
					compare_field("origin_y", vtx.origin_y, want.origin_y);
					compare_field("size_x", vtx.size_x, want.size_x);
					compare_field("size_y", vtx.size_y, want.size_y);
					compare_field("bad", vtx.bad, want.bad);
					compare_field("last", vtx.last, want.last);
				end
				vtx_seen++;
			end
			if (req.valid && req.ready) begin
				predict_vertices(req.func, req.offset_x, req.offset_y, req.quad_width,
					req.quad_height, req.tex_left, req.tex_top, req.tex_right,
					req.tex_bottom);
			end
			queued = expected_vertices.size();
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sprite quad vertex generator. Directed quads
// hit the field extremes, saturation and every reject reason; random quads,
// mostly well formed with spread magnitudes, follow. The checker beside the
// block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

	localparam int LIMIT = 200_000;

	localparam logic signed [31:0] ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] MAXP = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MINN = 32'sh8000_0000;

	typedef struct {
		logic               fn;
		logic signed [31:0] ox, oy, qw, qh, lf, tp, rt, bt;
	} quad_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sqvg_req_if req_ch ();
	sqvg_vtx_if vtx_ch ();

	int mismatches;
	int outstanding;
	int cycles     = 0;
	int burst_left = 0;
	// raised by the stimulus, cleared by the receiver once its long stall is over
	bit long_hold  = 1'b0;

	sprite_quad_vertex_generator_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.vtx    (vtx_ch)
	);

	sqvg_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.vtx     (vtx_ch),
		.errors  (mismatches),
		.pending (outstanding)
	);

	always #5 clk = ~clk;

	// hard stop: generous multiple of the slowest legal run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// --------------------------------------------------------------------------
	// Random helpers
	// --------------------------------------------------------------------------

	// 0 .. 2^32-1 with the bit count itself random, so small and huge both show
	function automatic longint rand_bits();
		int k;
		k = $urandom_range(0, 32);
		return longint'($urandom) & ((longint'(1) << k) - 1);
	endfunction

	function automatic longint rand_signed();
		longint m;
		m = rand_bits() & 64'h7FFF_FFFF;
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// well-formed inclusive edge pair, lo <= hi, spanning anything up to the
	// whole 32-bit range
	function automatic void pick_span(output logic signed [31:0] lo,
			output logic signed [31:0] hi);
		longint span, room, base;
		span = rand_bits();
		room = 64'hFFFF_FFFF - span;
		if ($urandom_range(0, 1)) begin
			base = longint'($urandom) % (room + 1);
		end else begin
			// lo near a spread signed value; pulled down if hi would overflow
			base = rand_signed() + 64'h8000_0000;
			if (base > room) begin
				base = room;
			end
		end
		lo = 32'(base - 64'h8000_0000);
		hi = 32'(base + span - 64'h8000_0000);
	endfunction

	// turn a good edge pair into an inverted one
	function automatic void invert_span(inout logic signed [31:0] lo,
			inout logic signed [31:0] hi);
		logic signed [31:0] t;
		if (lo == hi) begin
			if (hi == MINN) begin
				lo = lo + 1;
			end else begin
				hi = hi - 1;
			end
		end
		if (lo < hi) begin
			t  = lo;
			lo = hi;
			hi = t;
		end
	endfunction

	function automatic quad_t rand_quad();
		quad_t q;
		int    kind;
		kind = $urandom_range(0, 9);
		q.fn = (kind == 5 || kind == 6);
		q.ox = $urandom_range(0, 1) ? 32'($urandom) : 32'(rand_signed());
		q.oy = $urandom_range(0, 1) ? 32'($urandom) : 32'(rand_signed());
		if (q.fn) begin
			// ignored in this mode, so anything goes, negatives included
			q.qw = $urandom;
			q.qh = $urandom;
		end else begin
			q.qw = 32'(rand_bits() & 64'h7FFF_FFFF);
			q.qh = 32'(rand_bits() & 64'h7FFF_FFFF);
		end
		pick_span(q.lf, q.rt);
		pick_span(q.tp, q.bt);
		if (kind == 7) begin
			// one defect on an otherwise sane quad
			case ($urandom_range(0, 3))
				0: begin
					q.fn = 1'b0;
					q.qw = 32'(-(rand_bits() & 64'h7FFF_FFFF) - 1);
				end
				1: begin
					q.fn = 1'b0;
					q.qh = 32'(-(rand_bits() & 64'h7FFF_FFFF) - 1);
				end
				2: invert_span(q.lf, q.rt);
				default: invert_span(q.tp, q.bt);
			endcase
		end else if (kind >= 8) begin
			// raw noise, mostly rejected
			q.fn = $urandom_range(0, 1);
			q.qw = $urandom;
			q.qh = $urandom;
			q.lf = $urandom;
			q.tp = $urandom;
			q.rt = $urandom;
			q.bt = $urandom;
		end
		return q;
	endfunction

	// --------------------------------------------------------------------------
	// Request side: one transfer per call. The sender runs in bursts; between
	// bursts valid drops for a random gap. Valid is only ever assigned once per
	// falling edge: a continuing burst leaves it high for the next call.
	// --------------------------------------------------------------------------
	task automatic send_quad(input quad_t q);
		req_ch.valid       <= 1'b1;
		req_ch.func        <= q.fn;
		req_ch.offset_x    <= q.ox;
		req_ch.offset_y    <= q.oy;
		req_ch.quad_width  <= q.qw;
		req_ch.quad_height <= q.qh;
		req_ch.tex_left    <= q.lf;
		req_ch.tex_top     <= q.tp;
		req_ch.tex_right   <= q.rt;
		req_ch.tex_bottom  <= q.bt;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			// now and then a long unbroken burst
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	// --------------------------------------------------------------------------
	// Vertex side: ready follows a pattern picked at random for each window
	// (always ready, coin flip, a rotating mask, mostly stalled). On request it
	// holds off for a long stretch so the pipeline fills and backs up into the
	// request channel.
	// --------------------------------------------------------------------------
	initial begin
		int          mode;
		int          window;
		int          phase;
		logic [31:0] mask;
		mode   = 0;
		window = 0;
		phase  = 0;
		mask   = '1;
		vtx_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				vtx_ch.ready <= 1'b0;
				repeat (300) @(negedge clk);
				long_hold = 1'b0;
			end else begin
				if (window == 0) begin
					mode   = $urandom_range(0, 3);
					window = $urandom_range(20, 80);
					mask   = $urandom;
				end
				window--;
				phase++;
				case (mode)
					0: vtx_ch.ready <= 1'b1;
					1: vtx_ch.ready <= $urandom_range(0, 1);
					2: vtx_ch.ready <= mask[phase % 32];
					default: vtx_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// --------------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------------
	initial begin
		int n;
		req_ch.valid       <= 1'b0;
		req_ch.func        <= 1'b0;
		req_ch.offset_x    <= '0;
		req_ch.offset_y    <= '0;
		req_ch.quad_width  <= '0;
		req_ch.quad_height <= '0;
		req_ch.tex_left    <= '0;
		req_ch.tex_top     <= '0;
		req_ch.tex_right   <= '0;
		req_ch.tex_bottom  <= '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// unit quad on a single texel: repeat of exactly one
		send_quad(quad_t'{1'b0, 0, 0, ONE, ONE, 0, 0, 0, 0});
		// size taken from the rectangle
		send_quad(quad_t'{1'b1, 32'sh000A_0000, 32'sh0014_0000, 0, 0,
			0, 0, 32'sh000F_0000, 32'sh0007_0000});
		// fractional offsets and sizes, repeat truncated toward zero
		send_quad(quad_t'{1'b0, 32'sh0064_8000, 32'shFFFC_C000, 32'sh0030_C000,
			32'sh0011_8000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0021_8000,
			32'sh000A_0000});
		// largest offsets and sizes: positions pin at the top
		send_quad(quad_t'{1'b0, MAXP, MAXP, MAXP, MAXP, 0, 0, 0, 0});
		// largest width over a texel a hair wider than one
		send_quad(quad_t'{1'b0, 0, 0, MAXP, 1, 0, 0, 1, 1});
		// most negative offsets, zero size, rectangle at the bottom of the range
		send_quad(quad_t'{1'b0, MINN, MINN, 0, 0, MINN, MINN, MINN, MINN});
		// negative fraction floors away from zero; rectangle at the top of the range
		send_quad(quad_t'{1'b0, 32'shFFFF_8000, 32'shFFFF_FFFF, ONE, ONE,
			MAXP, MAXP, MAXP, MAXP});
		// whole-range rectangle: texture size saturates, size from rectangle, then given
		send_quad(quad_t'{1'b1, 0, 0, 0, 0, MINN, MINN, MAXP, MAXP});
		send_quad(quad_t'{1'b0, 0, 0, MAXP, MAXP, MINN, MINN, MAXP, MAXP});
		// zero on-screen size
		send_quad(quad_t'{1'b0, 0, 0, 0, 0, 0, 0, 32'sh0004_0000, 32'sh0004_0000});
		// negative width is ignored when size comes from the rectangle
		send_quad(quad_t'{1'b1, 32'sh0005_0000, 32'sh0005_0000, 32'shFFFF_FFFF, MINN,
			0, 0, 32'sh0003_0000, 32'sh0003_0000});
		// position just past the top and exactly at the bottom of 16 bits
		send_quad(quad_t'{1'b0, 32'sh7FFF_0000, 32'sh8000_0000, ONE, ONE,
			0, 0, ONE, ONE});
		// all ones: size from rectangle, rectangle a single texel at -1 raw
		send_quad(quad_t'{1'b1, '1, '1, '1, '1, '1, '1, '1, '1});
		// rejects: negative width, negative height, inverted x, inverted y
		send_quad(quad_t'{1'b0, 0, 0, 32'shFFFF_FFFF, ONE, 0, 0, ONE, ONE});
		send_quad(quad_t'{1'b0, 0, 0, ONE, MINN, 0, 0, ONE, ONE});
		send_quad(quad_t'{1'b0, 0, 0, ONE, ONE, ONE, 0, 0, ONE});
		send_quad(quad_t'{1'b0, 0, 0, ONE, ONE, 0, ONE, ONE, 32'sh0000_FFFF});
		// inverted rectangle with size taken from it
		send_quad(quad_t'{1'b1, 0, 0, ONE, ONE, MAXP, 0, MINN, 0});

		// sender goes quiet until every vertex so far has come back
		req_ch.valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end

		for (n = 0; n < 100; n++) begin
			if (n == 40) begin
				long_hold = 1'b1;
			end
			send_quad(rand_quad());
		end

		req_ch.valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		// catch any stray vertex past the pipeline depth
		repeat (40) @(negedge clk);
		if (mismatches == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
